FILE: design/epc_pkg.sv
`timescale 1ns / 1ps

package epc_pkg;

  // Default number of entries in the open-id store.
  localparam int MAX_OPEN_IDS_DEF = 256;

  // One input item: a way given by its two endpoint ids.
  typedef struct packed {
    logic [31:0] first_node;
    logic [31:0] final_node;
    logic        short_way;
    logic        last_way;
  } in_item_t;

  // One result item: the report of a finished set of ways.
  typedef struct packed {
    logic        odd_found;
    logic [31:0] odd_node;
    logic        table_overflow;
  } out_item_t;

  // One entry of the open-id store.
  typedef struct packed {
    logic        valid;
    logic [31:0] id;
  } slot_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOGGLE,
    ST_REPORT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic key_final;
    logic scan_step;
    logic wr_clear;
    logic insert;
    logic report;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_short;
    logic in_last;
    logic item_last;
    logic on_final;
    logic hit;
    logic scan_end;
    logic out_free;
  } ctl_sts_t;

endpackage

FILE: design/endpoint_parity_checker_top.sv
`timescale 1ns / 1ps

// Endpoint parity checker: tells whether a set of ways closes into rings.
// Input channel (in_valid, in_stall, in_data): one item per way with its two
// endpoint ids, a short-way flag (the item toggles nothing) and a last-way flag.
// Output channel (out_valid, out_stall, out_data): one item per set, issued
// after the last way, with the odd flag, the smallest open id and the overflow
// flag. Each endpoint id is toggled in a store of MAX_OPEN_IDS entries.
// Timing: with F entries in use, each endpoint scans those F entries one entry
// per cycle through the store's single port, so a way runs two such scans.
// The last way adds a report scan; the report then clears the store by resetting
// its fill count. A short way that is not last is taken in the idle state and
// toggles nothing.
// Reset (rst, synchronous) empties the store at once; no clearing pass is run.
// A stalled result is held in the output register while the next item is
// taken; only a new report waits for that register to empty.

module endpoint_parity_checker_top import epc_pkg::*; #(
  parameter int MAX_OPEN_IDS = MAX_OPEN_IDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequencer for the toggles and the report scan.
  epc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Store, scan counters and output register.
  epc_datapath #(
    .MAX_OPEN_IDS (MAX_OPEN_IDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: design/epc_ctrl.sv
`timescale 1ns / 1ps

module epc_ctrl import epc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state;
  ctl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept     = 1'b1;
          cmd.scan_start = 1'b1;
          if (!sts.in_short) begin
            state_next = ST_TOGGLE;
          end else if (sts.in_last) begin
            state_next = ST_REPORT;
          end
        end
      end
      ST_TOGGLE: begin
        if (sts.hit || sts.scan_end) begin
          // The scan of one endpoint is decided: remove on a match, else add.
          cmd.wr_clear = sts.hit;
          cmd.insert   = !sts.hit;
          if (!sts.on_final) begin
            cmd.scan_start = 1'b1;
            cmd.key_final  = 1'b1;
          end else if (sts.item_last) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_REPORT;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_REPORT: begin
        if (sts.scan_end) begin
          if (sts.out_free) begin
            cmd.report = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A report is only issued after a completed scan.
  assert property (@(posedge clk) disable iff (rst)
    cmd.report |-> sts.scan_end && sts.out_free)
    else $error("report issued before the scan finished");

  // Items are taken only in the idle state.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_IDLE) || $past(cmd.scan_start))
    else $error("item accepted without starting its work");

  // A match and an insertion never happen together.
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_clear && cmd.insert))
    else $error("clear and insert in the same cycle");

endmodule

FILE: design/epc_datapath.sv
`timescale 1ns / 1ps

module epc_datapath import epc_pkg::*; #(
  parameter int MAX_OPEN_IDS = MAX_OPEN_IDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  ctl_cmd_t  cmd,
  output ctl_sts_t  sts
);

  localparam int AW = (MAX_OPEN_IDS > 1) ? $clog2(MAX_OPEN_IDS) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH = CW'(MAX_OPEN_IDS);

  // Open-id store; entries at or above the fill count were never written
  // since the last clear and are treated as free.
  slot_t slots [MAX_OPEN_IDS];

  in_item_t        item;
  logic            key_sel;
  logic [31:0]     key;
  logic [CW-1:0]   fill;
  logic [CW-1:0]   idx;
  logic [AW-1:0]   chk_idx;
  logic            pend;
  slot_t           rd_word;
  logic            free_found;
  logic [AW-1:0]   free_idx;
  logic            found;
  logic [31:0]     min_id;
  logic            overflow;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  slot_t           wr_word;
  logic            hit;
  logic            scan_end;
  logic            out_free;

  assign key      = key_sel ? item.final_node : item.first_node;
  assign hit      = pend && rd_word.valid && (rd_word.id == key);
  assign scan_end = !pend && (idx == fill);
  assign out_free = !out_valid || !out_stall;

  // Status toward the controller.
  always_comb begin
    sts.in_short  = in_data.short_way;
    sts.in_last   = in_data.last_way;
    sts.item_last = item.last_way;
    sts.on_final  = key_sel;
    sts.hit       = hit;
    sts.scan_end  = scan_end;
    sts.out_free  = out_free;
  end

  // Store write: clear a matched entry, or add the key at the lowest free entry.
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = chk_idx;
    wr_word.valid = 1'b0;
    wr_word.id    = key;
    if (cmd.wr_clear) begin
      wr_en = 1'b1;
    end else if (cmd.insert) begin
      wr_word.valid = 1'b1;
      if (free_found) begin
        wr_en   = 1'b1;
        wr_addr = free_idx;
      end else if (fill < DEPTH) begin
        wr_en   = 1'b1;
        wr_addr = fill[AW-1:0];
      end
    end
  end

  // Store port: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_addr] <= wr_word;
    end
    rd_word <= slots[idx[AW-1:0]];
  end

  // Accepted item and key selection.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
    end
    if (cmd.scan_start) begin
      key_sel <= cmd.key_final;
    end
  end

  // Scan sequencing, free-entry search and minimum tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      pend <= 1'b0;
    end else if (cmd.scan_start) begin
      idx  <= '0;
      pend <= 1'b0;
    end else if (cmd.scan_step) begin
      if (idx < fill) begin
        chk_idx <= idx[AW-1:0];
        idx     <= idx + CW'(1);
        pend    <= 1'b1;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      free_found <= 1'b0;
      found      <= 1'b0;
      min_id     <= '0;
    end else if (pend) begin
      if (!rd_word.valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
      if (rd_word.valid && (!found || (rd_word.id < min_id))) begin
        min_id <= rd_word.id;
      end
      if (rd_word.valid) begin
        found <= 1'b1;
      end
    end
  end

  // Fill count and overflow flag; both are cleared with each report.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      overflow <= 1'b0;
    end else if (cmd.report) begin
      fill     <= '0;
      overflow <= 1'b0;
    end else if (cmd.insert && !free_found) begin
      if (fill < DEPTH) begin
        fill <= fill + CW'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.report) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_data.odd_found      <= found;
      out_data.odd_node       <= min_id;
      out_data.table_overflow <= overflow;
    end
  end

  // The fill count never passes the store depth.
  assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH)
    else $error("fill count beyond store depth");

  // A new entry beyond the fill count raises the count by one.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.insert && !free_found && (fill < DEPTH) && !cmd.report)
      |=> fill == $past(fill) + CW'(1))
    else $error("fill count not advanced on append");

  // A matched entry is cleared only from a checked read.
  assert property (@(posedge clk) disable iff (rst)
    cmd.wr_clear |-> pend && rd_word.valid)
    else $error("clear without a matching read");

endmodule
